// File: design/csshp_pkg.sv
// ----------------------------------------------------------------------------
// csshp_pkg
// Shared types and constants of the corner speed shaper.
// ----------------------------------------------------------------------------
package csshp_pkg;

  localparam int SQ_IN_W  = 50;
  localparam int SQ_RT_W  = 25;
  localparam int DV_NUM_W = 64;
  localparam int DV_DEN_W = 40;
  localparam int DIST_W   = 42;
  localparam int PROD_W   = 64;
  localparam int SCALE_SH = 14;

  localparam int MODE_EN   = 0;
  localparam int MODE_AGGR = 1;

  localparam logic [30:0] PI_Q29 = 31'd1686629713;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_COUNT     = 3'd1,
    REG_SEARCH    = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_ENTRY     = 3'd4,
    REG_EXIT      = 3'd5,
    REG_ENTRY_SC  = 3'd6,
    REG_EXIT_SC   = 3'd7
  } csshp_reg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] count;
    logic [23:0] search;
    logic [31:0] thr;
    logic [23:0] entry;
    logic [23:0] exit_d;
    logic [31:0] entry_sc;
    logic [31:0] exit_sc;
  } csshp_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] speed;
  } csshp_res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NRD, ST_NWT, ST_NSQX, ST_NSQY, ST_NCMP,
    ST_PRD, ST_PWT, ST_SCHK, ST_WCHK, ST_BRD, ST_BWT,
    ST_SQX, ST_SQY, ST_SQGO, ST_SQWT, ST_SEG, ST_AM1, ST_AM2, ST_ACMP,
    ST_CVMUL, ST_CVGO, ST_CVWT, ST_ZONE, ST_ZMUL, ST_ZNUM,
    ST_MLO, ST_MHI, ST_DVGO, ST_DVWT, ST_DONE
  } csshp_state_t;

  function automatic logic [24:0] abs_diff(input logic signed [23:0] a,
                                           input logic signed [23:0] b);
    logic signed [24:0] d;
    d = 25'(a) - 25'(b);
    return d[24] ? 25'(-d) : 25'(d);
  endfunction

  function automatic logic [15:0] abs_dyaw(input logic [15:0] ya,
                                           input logic [15:0] yb);
    logic [15:0] dif;
    dif = yb - ya;
    return dif[15] ? 16'(17'h10000 - 17'(dif)) : dif;
  endfunction

endpackage

// File: design/corner_speed_shaper_top.sv
// ----------------------------------------------------------------------------
// corner_speed_shaper_top
// Slows the vehicle around the sharpest corner ahead on a waypoint ring.
//
//   channel  dir  handshake            beat
//   in_      in   in_valid/in_ready    load waypoint or speed query
//   out_     out  out_valid/out_ready  shaped target speed per query
//   cfg_     in   cfg_valid/cfg_ready  register index and write data
//
// A query covers n waypoints in the nearest search, s segments scanned for
// the apex and w segments walked back from apex, with a square root per
// segment and runs of the divider. One query is in flight.
// Reset is synchronous and clears the sequencer and registers.
// A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module corner_speed_shaper_top #(
  parameter int MAX_WAYPOINTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [9:0]         in_point_index,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic [15:0]        in_point_yaw,
  input  logic signed [23:0] in_ego_x,
  input  logic signed [23:0] in_ego_y,
  input  logic [15:0]        in_base_speed,
  input  logic               in_overtaking,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_target_speed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  csshp_pkg::csshp_cfg_t cfg_r;
  csshp_pkg::csshp_res_t res;
  logic                  core_idle;
  logic                  in_fire;
  logic                  out_valid_r;
  logic [15:0]           out_speed_r;
  logic                  out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = core_idle;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (csshp_pkg::csshp_reg_t'(cfg_index))
        csshp_pkg::REG_MODE:      cfg_r.mode     <= cfg_wdata[1:0];
        csshp_pkg::REG_COUNT:     cfg_r.count    <= cfg_wdata[10:0];
        csshp_pkg::REG_SEARCH:    cfg_r.search   <= cfg_wdata[23:0];
        csshp_pkg::REG_THRESHOLD: cfg_r.thr      <= cfg_wdata;
        csshp_pkg::REG_ENTRY:     cfg_r.entry    <= cfg_wdata[23:0];
        csshp_pkg::REG_EXIT:      cfg_r.exit_d   <= cfg_wdata[23:0];
        csshp_pkg::REG_ENTRY_SC:  cfg_r.entry_sc <= cfg_wdata;
        csshp_pkg::REG_EXIT_SC:   cfg_r.exit_sc  <= cfg_wdata;
      endcase
    end
  end

  csshp_core #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .load_en    (in_fire && !in_command),
    .load_idx   (in_point_index),
    .load_x     (in_point_x),
    .load_y     (in_point_y),
    .load_yaw   (in_point_yaw),
    .query_en   (in_fire && in_command),
    .ego_x      (in_ego_x),
    .ego_y      (in_ego_y),
    .query_speed(in_base_speed),
    .overtaking (in_overtaking),
    .out_free   (out_free),
    .idle       (core_idle),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_speed_r <= res.speed;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target_speed = out_speed_r;

  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid_r || out_ready))
    else $error("result produced while output register is held");

  a_query_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command) |=> !in_ready)
    else $error("input taken while query in progress");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_command) |=> !res.valid)
    else $error("load beat produced a result");

endmodule

// File: design/csshp_isqrt.sv
// ----------------------------------------------------------------------------
// csshp_isqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module csshp_isqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [csshp_pkg::SQ_IN_W-1:0]     arg,
  output logic                              busy,
  output logic [csshp_pkg::SQ_RT_W-1:0]     root
);

  localparam int RW = csshp_pkg::SQ_RT_W + 2;

  logic [csshp_pkg::SQ_IN_W-1:0] val_r;
  logic [RW-1:0]                 rem_r;
  logic [csshp_pkg::SQ_RT_W-1:0] root_r;
  logic [4:0]                    cnt_r;
  logic                          busy_r;
  logic [RW+1:0]                 rem_t;
  logic [RW+1:0]                 trial;

  assign rem_t = {rem_r, val_r[csshp_pkg::SQ_IN_W-1 -: 2]};
  assign trial = (RW+2)'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == 5'd1) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= arg;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= 5'(csshp_pkg::SQ_RT_W);
    end else if (busy_r) begin
      val_r <= val_r << 2;
      cnt_r <= cnt_r - 5'd1;
      if (rem_t >= trial) begin
        rem_r  <= RW'(rem_t - trial);
        root_r <= {root_r[csshp_pkg::SQ_RT_W-2:0], 1'b1};
      end else begin
        rem_r  <= RW'(rem_t);
        root_r <= {root_r[csshp_pkg::SQ_RT_W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// File: design/csshp_div.sv
// ----------------------------------------------------------------------------
// csshp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csshp_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [csshp_pkg::DV_NUM_W-1:0]     num,
  input  logic [csshp_pkg::DV_DEN_W-1:0]     den,
  output logic                               busy,
  output logic [csshp_pkg::DV_NUM_W-1:0]     quot
);

  localparam int NW = csshp_pkg::DV_NUM_W;
  localparam int DW = csshp_pkg::DV_DEN_W;

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [6:0]    cnt_r;
  logic          busy_r;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_r, q_r[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == 7'd1) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= 7'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      q_r   <= {q_r[NW-2:0], fits};
      rem_r <= fits ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

// File: design/csshp_core.sv
// ----------------------------------------------------------------------------
// csshp_core
// Waypoint store, sequencer and shared multiplier of the corner speed shaper.
// ----------------------------------------------------------------------------
module csshp_core #(
  parameter int MAX_WAYPOINTS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  csshp_pkg::csshp_cfg_t    cfg,
  input  logic                     load_en,
  input  logic [9:0]               load_idx,
  input  logic signed [23:0]       load_x,
  input  logic signed [23:0]       load_y,
  input  logic [15:0]              load_yaw,
  input  logic                     query_en,
  input  logic signed [23:0]       ego_x,
  input  logic signed [23:0]       ego_y,
  input  logic [15:0]              query_speed,
  input  logic                     overtaking,
  input  logic                     out_free,
  output logic                     idle,
  output csshp_pkg::csshp_res_t    res
);

  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int DW = csshp_pkg::DIST_W;
  localparam int SW = csshp_pkg::SQ_IN_W;
  localparam int LW = csshp_pkg::SQ_RT_W;

  logic [63:0] mem [MAX_WAYPOINTS];
  logic [63:0] rdata_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  csshp_pkg::csshp_state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt, nearest_r, nearest_nxt, a_r, a_nxt, apex_r, apex_nxt;
  logic [AW-1:0] b_w;
  logic [CW-1:0] step_r, step_nxt, n_r, n_nxt, n_w;
  logic [SW-1:0] best_r, best_nxt, hold_r, hold_nxt, sq_sum;
  logic [24:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [23:0] pa_x_r, pa_x_nxt, pa_y_r, pa_y_nxt, pb_x_r, pb_x_nxt, pb_y_r, pb_y_nxt;
  logic [15:0]   pa_yaw_r, pa_yaw_nxt, pb_yaw_r, pb_yaw_nxt;
  logic [LW-1:0] len_r, len_nxt, max_len_r, max_len_nxt;
  logic [DW-1:0] trav_r, trav_nxt, to_apex_r, to_apex_nxt, fa_r, fa_nxt, ta_w;
  logic [15:0]   max_dyaw_r, max_dyaw_nxt, ad_w;
  logic          found_r, found_nxt, phase_r, phase_nxt, ovt_r, ovt_nxt;
  logic signed [23:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [15:0]   base_r, base_nxt, zs_r, zs_nxt, res_r, res_nxt, es_w, xs_w;
  logic [23:0]   zspan_r, zspan_nxt, ed_w;
  logic [37:0]   zext_r, zext_nxt, den_r, den_nxt;
  logic [40:0]   num_r, num_nxt;
  logic [31:0]   mul_a, mul_b;
  logic [csshp_pkg::PROD_W-1:0] prod_r;
  logic          res_valid, alt_w;

  logic                              sq_start, sq_busy;
  logic [SW-1:0]                     sq_arg;
  logic [LW-1:0]                     sq_root;
  logic                              dv_start, dv_busy;
  logic [csshp_pkg::DV_NUM_W-1:0]    dv_num, dv_quot;
  logic [csshp_pkg::DV_DEN_W-1:0]    dv_den;

  csshp_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .arg  (sq_arg),
    .busy (sq_busy),
    .root (sq_root)
  );

  csshp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dv_start),
    .num  (dv_num),
    .den  (dv_den),
    .busy (dv_busy),
    .quot (dv_quot)
  );

  // waypoint store: {yaw, y, x}
  assign wr_en = load_en && (state_r == csshp_pkg::ST_IDLE) &&
                 (32'(load_idx) < 32'(MAX_WAYPOINTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(load_idx)] <= {load_yaw, load_y, load_x};
    end
    rdata_r <= mem[rd_addr];
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod_r <= csshp_pkg::PROD_W'(mul_a) * csshp_pkg::PROD_W'(mul_b);
  end

  assign n_w   = (32'(cfg.count) > 32'(MAX_WAYPOINTS)) ? CW'(MAX_WAYPOINTS) : CW'(cfg.count);
  assign b_w   = (32'(a_r) + 32'd1 == 32'(n_r)) ? '0 : a_r + AW'(1);
  assign ad_w  = csshp_pkg::abs_dyaw(pa_yaw_r, pb_yaw_r);
  assign sq_sum = hold_r + prod_r[SW-1:0];
  assign alt_w = ovt_r && cfg.mode[csshp_pkg::MODE_AGGR];
  assign es_w  = alt_w ? cfg.entry_sc[31:16] : cfg.entry_sc[15:0];
  assign xs_w  = alt_w ? cfg.exit_sc[31:16] : cfg.exit_sc[15:0];
  assign ta_w  = (apex_r == nearest_r) ? '0 : to_apex_r;
  assign ed_w  = (cfg.entry == '0) ? 24'd1 : cfg.entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csshp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;   nearest_r <= nearest_nxt; a_r <= a_nxt;     apex_r <= apex_nxt;
    step_r <= step_nxt; n_r <= n_nxt;             best_r <= best_nxt; hold_r <= hold_nxt;
    dx_r <= dx_nxt;     dy_r <= dy_nxt;
    pa_x_r <= pa_x_nxt; pa_y_r <= pa_y_nxt;       pa_yaw_r <= pa_yaw_nxt;
    pb_x_r <= pb_x_nxt; pb_y_r <= pb_y_nxt;       pb_yaw_r <= pb_yaw_nxt;
    len_r <= len_nxt;   max_len_r <= max_len_nxt; max_dyaw_r <= max_dyaw_nxt;
    trav_r <= trav_nxt; to_apex_r <= to_apex_nxt; fa_r <= fa_nxt;
    found_r <= found_nxt; phase_r <= phase_nxt;   ovt_r <= ovt_nxt;
    ex_r <= ex_nxt;     ey_r <= ey_nxt;           base_r <= base_nxt;
    zs_r <= zs_nxt;     zspan_r <= zspan_nxt;     zext_r <= zext_nxt;
    den_r <= den_nxt;   num_r <= num_nxt;         res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;   nearest_nxt = nearest_r; a_nxt = a_r;       apex_nxt = apex_r;
    step_nxt = step_r; n_nxt = n_r;             best_nxt = best_r; hold_nxt = hold_r;
    dx_nxt = dx_r;     dy_nxt = dy_r;
    pa_x_nxt = pa_x_r; pa_y_nxt = pa_y_r;       pa_yaw_nxt = pa_yaw_r;
    pb_x_nxt = pb_x_r; pb_y_nxt = pb_y_r;       pb_yaw_nxt = pb_yaw_r;
    len_nxt = len_r;   max_len_nxt = max_len_r; max_dyaw_nxt = max_dyaw_r;
    trav_nxt = trav_r; to_apex_nxt = to_apex_r; fa_nxt = fa_r;
    found_nxt = found_r; phase_nxt = phase_r;   ovt_nxt = ovt_r;
    ex_nxt = ex_r;     ey_nxt = ey_r;           base_nxt = base_r;
    zs_nxt = zs_r;     zspan_nxt = zspan_r;     zext_nxt = zext_r;
    den_nxt = den_r;   num_nxt = num_r;         res_nxt = res_r;
    mul_a = '0; mul_b = '0;
    sq_start = 1'b0; sq_arg = '0;
    dv_start = 1'b0; dv_num = '0; dv_den = '0;
    rd_addr = a_r;
    res_valid = 1'b0;

    unique case (state_r)
      csshp_pkg::ST_IDLE: begin
        if (query_en) begin
          ex_nxt = ego_x; ey_nxt = ego_y; base_nxt = query_speed; ovt_nxt = overtaking;
          n_nxt = n_w;
          if (!cfg.mode[csshp_pkg::MODE_EN] || query_speed == '0 || 32'(n_w) < 32'd3) begin
            res_nxt = query_speed;
            state_nxt = csshp_pkg::ST_DONE;
          end else begin
            idx_nxt = '0;
            best_nxt = '1;
            state_nxt = csshp_pkg::ST_NRD;
          end
        end
      end
      csshp_pkg::ST_NRD: begin
        rd_addr = idx_r;
        state_nxt = csshp_pkg::ST_NWT;
      end
      csshp_pkg::ST_NWT: begin
        rd_addr = idx_r;
        dx_nxt = csshp_pkg::abs_diff(rdata_r[23:0], ex_r);
        dy_nxt = csshp_pkg::abs_diff(rdata_r[47:24], ey_r);
        state_nxt = csshp_pkg::ST_NSQX;
      end
      csshp_pkg::ST_NSQX: begin
        mul_a = 32'(dx_r); mul_b = 32'(dx_r);
        state_nxt = csshp_pkg::ST_NSQY;
      end
      csshp_pkg::ST_NSQY: begin
        mul_a = 32'(dy_r); mul_b = 32'(dy_r);
        hold_nxt = prod_r[SW-1:0];
        state_nxt = csshp_pkg::ST_NCMP;
      end
      csshp_pkg::ST_NCMP: begin
        if (sq_sum < best_r) begin
          best_nxt = sq_sum;
          nearest_nxt = idx_r;
        end
        if (32'(idx_r) + 32'd1 == 32'(n_r)) begin
          a_nxt = (sq_sum < best_r) ? idx_r : nearest_r;
          phase_nxt = 1'b0; step_nxt = '0; trav_nxt = '0; found_nxt = 1'b0;
          max_dyaw_nxt = '0; max_len_nxt = LW'(1);
          state_nxt = csshp_pkg::ST_PRD;
        end else begin
          idx_nxt = idx_r + AW'(1);
          state_nxt = csshp_pkg::ST_NRD;
        end
      end
      csshp_pkg::ST_PRD: begin
        state_nxt = csshp_pkg::ST_PWT;
      end
      csshp_pkg::ST_PWT: begin
        pa_x_nxt = rdata_r[23:0]; pa_y_nxt = rdata_r[47:24]; pa_yaw_nxt = rdata_r[63:48];
        state_nxt = phase_r ? csshp_pkg::ST_WCHK : csshp_pkg::ST_SCHK;
      end
      csshp_pkg::ST_SCHK: begin
        if (32'(step_r) < 32'(n_r) && trav_r < DW'(cfg.search)) begin
          state_nxt = csshp_pkg::ST_BRD;
        end else if (found_r) begin
          state_nxt = csshp_pkg::ST_CVMUL;
        end else begin
          res_nxt = base_r;
          state_nxt = csshp_pkg::ST_DONE;
        end
      end
      csshp_pkg::ST_WCHK: begin
        if (a_r == nearest_r) begin
          if (fa_r != '0 && fa_r <= DW'(cfg.exit_d)) begin
            zs_nxt = xs_w;
            zspan_nxt = fa_r[23:0];
            zext_nxt = {cfg.exit_d - fa_r[23:0], 14'b0};
            den_nxt = {cfg.exit_d, 14'b0};
            state_nxt = csshp_pkg::ST_ZMUL;
          end else begin
            res_nxt = base_r;
            state_nxt = csshp_pkg::ST_DONE;
          end
        end else begin
          state_nxt = csshp_pkg::ST_BRD;
        end
      end
      csshp_pkg::ST_BRD: begin
        rd_addr = b_w;
        state_nxt = csshp_pkg::ST_BWT;
      end
      csshp_pkg::ST_BWT: begin
        rd_addr = b_w;
        pb_x_nxt = rdata_r[23:0]; pb_y_nxt = rdata_r[47:24]; pb_yaw_nxt = rdata_r[63:48];
        dx_nxt = csshp_pkg::abs_diff(rdata_r[23:0], pa_x_r);
        dy_nxt = csshp_pkg::abs_diff(rdata_r[47:24], pa_y_r);
        state_nxt = csshp_pkg::ST_SQX;
      end
      csshp_pkg::ST_SQX: begin
        mul_a = 32'(dx_r); mul_b = 32'(dx_r);
        state_nxt = csshp_pkg::ST_SQY;
      end
      csshp_pkg::ST_SQY: begin
        mul_a = 32'(dy_r); mul_b = 32'(dy_r);
        hold_nxt = prod_r[SW-1:0];
        state_nxt = csshp_pkg::ST_SQGO;
      end
      csshp_pkg::ST_SQGO: begin
        sq_start = 1'b1;
        sq_arg = sq_sum;
        state_nxt = csshp_pkg::ST_SQWT;
      end
      csshp_pkg::ST_SQWT: begin
        if (!sq_busy) begin
          len_nxt = sq_root;
          state_nxt = csshp_pkg::ST_SEG;
        end
      end
      csshp_pkg::ST_SEG: begin
        if (phase_r) begin
          fa_nxt = fa_r + DW'(len_r);
          a_nxt = b_w; pa_x_nxt = pb_x_r; pa_y_nxt = pb_y_r; pa_yaw_nxt = pb_yaw_r;
          state_nxt = csshp_pkg::ST_WCHK;
        end else if (len_r == '0) begin
          step_nxt = step_r + CW'(1);
          a_nxt = b_w; pa_x_nxt = pb_x_r; pa_y_nxt = pb_y_r; pa_yaw_nxt = pb_yaw_r;
          state_nxt = csshp_pkg::ST_SCHK;
        end else begin
          state_nxt = csshp_pkg::ST_AM1;
        end
      end
      csshp_pkg::ST_AM1: begin
        mul_a = 32'(ad_w); mul_b = 32'(max_len_r);
        state_nxt = csshp_pkg::ST_AM2;
      end
      csshp_pkg::ST_AM2: begin
        mul_a = 32'(max_dyaw_r); mul_b = 32'(len_r);
        hold_nxt = prod_r[SW-1:0];
        state_nxt = csshp_pkg::ST_ACMP;
      end
      csshp_pkg::ST_ACMP: begin
        if (hold_r > prod_r[SW-1:0]) begin
          max_dyaw_nxt = ad_w;
          max_len_nxt = len_r;
          apex_nxt = b_w;
          found_nxt = 1'b1;
          to_apex_nxt = trav_r + DW'(len_r);
        end
        trav_nxt = trav_r + DW'(len_r);
        step_nxt = step_r + CW'(1);
        a_nxt = b_w; pa_x_nxt = pb_x_r; pa_y_nxt = pb_y_r; pa_yaw_nxt = pb_yaw_r;
        state_nxt = csshp_pkg::ST_SCHK;
      end
      csshp_pkg::ST_CVMUL: begin
        mul_a = 32'(max_dyaw_r); mul_b = 32'(csshp_pkg::PI_Q29);
        state_nxt = csshp_pkg::ST_CVGO;
      end
      csshp_pkg::ST_CVGO: begin
        dv_start = 1'b1;
        dv_num = prod_r >> 20;
        dv_den = csshp_pkg::DV_DEN_W'(max_len_r);
        state_nxt = csshp_pkg::ST_CVWT;
      end
      csshp_pkg::ST_CVWT: begin
        if (!dv_busy) begin
          if (dv_quot < csshp_pkg::DV_NUM_W'(cfg.thr)) begin
            res_nxt = base_r;
            state_nxt = csshp_pkg::ST_DONE;
          end else begin
            state_nxt = csshp_pkg::ST_ZONE;
          end
        end
      end
      csshp_pkg::ST_ZONE: begin
        if (ta_w <= DW'(cfg.entry)) begin
          zs_nxt = es_w;
          zspan_nxt = ed_w - ta_w[23:0];
          zext_nxt = {ta_w[23:0], 14'b0};
          den_nxt = {ed_w, 14'b0};
          state_nxt = csshp_pkg::ST_ZMUL;
        end else begin
          a_nxt = apex_r;
          phase_nxt = 1'b1;
          fa_nxt = '0;
          state_nxt = csshp_pkg::ST_PRD;
        end
      end
      csshp_pkg::ST_ZMUL: begin
        mul_a = 32'(zs_r); mul_b = 32'(zspan_r);
        state_nxt = csshp_pkg::ST_ZNUM;
      end
      csshp_pkg::ST_ZNUM: begin
        num_nxt = 41'(prod_r[39:0]) + 41'(zext_r);
        state_nxt = csshp_pkg::ST_MLO;
      end
      csshp_pkg::ST_MLO: begin
        mul_a = 32'(base_r); mul_b = num_r[31:0];
        state_nxt = csshp_pkg::ST_MHI;
      end
      csshp_pkg::ST_MHI: begin
        mul_a = 32'(base_r); mul_b = 32'(num_r[40:32]);
        hold_nxt = prod_r[SW-1:0];
        state_nxt = csshp_pkg::ST_DVGO;
      end
      csshp_pkg::ST_DVGO: begin
        dv_start = 1'b1;
        dv_num = {prod_r[31:0], 32'b0} + csshp_pkg::DV_NUM_W'(hold_r);
        dv_den = csshp_pkg::DV_DEN_W'(den_r);
        state_nxt = csshp_pkg::ST_DVWT;
      end
      csshp_pkg::ST_DVWT: begin
        if (!dv_busy) begin
          res_nxt = (dv_quot > 64'hFFFF) ? 16'hFFFF : dv_quot[15:0];
          state_nxt = csshp_pkg::ST_DONE;
        end
      end
      csshp_pkg::ST_DONE: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = csshp_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign idle      = (state_r == csshp_pkg::ST_IDLE);
  assign res.valid = res_valid;
  assign res.speed = res_r;

endmodule

// File: dv/corner_speed_shaper_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// corner_speed_shaper_top_test
// Checks the corner speed shaper against a cycle-free predictor: waypoint
// rings are loaded, registers set per phase, and queries near and far from
// corners are compared beat by beat with random sender bursts and receiver
// stalls.
// ----------------------------------------------------------------------------
module corner_speed_shaper_top_test;

  localparam int NWP = 1024;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct {
    logic        cmd;
    logic [9:0]  idx;
    logic [23:0] px;
    logic [23:0] py;
    logic [15:0] pyaw;
    logic [23:0] ex;
    logic [23:0] ey;
    logic [15:0] base;
    logic        ovt;
  } beat_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_command = 0, in_overtaking = 0;
  logic [9:0] in_point_index = 0;
  logic signed [23:0] in_point_x = 0, in_point_y = 0, in_ego_x = 0, in_ego_y = 0;
  logic [15:0] in_point_yaw = 0, in_base_speed = 0;
  logic out_ready = 0;
  logic cfg_valid = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;
  logic in_ready, out_valid, cfg_ready;
  logic [15:0] out_target_speed;

  corner_speed_shaper_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  beat_t pending[$];
  logic [15:0] speed_q[$];
  int mismatches = 0, queries = 0, loads = 0, results = 0;
  int cycles = 0;
  bit hold = 0;
  bit took = 0;
  int burst = 0, gap = 0;

  // predictor state
  logic signed [31:0] mx[NWP];
  logic signed [31:0] my[NWP];
  logic [15:0] myaw[NWP];
  logic [1:0] m_mode;
  logic [10:0] m_count;
  logic [31:0] m_search, m_thr, m_entry, m_exit, m_esc, m_xsc;

  function automatic longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned dist2(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = bx - ax;
    dy = by - ay;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint unsigned seg(int a, int b);
    return root(dist2(mx[a], my[a], mx[b], my[b]));
  endfunction

  function automatic longint unsigned walk(int n, int from, int to);
    longint unsigned d;
    int p;
    d = 0;
    p = from;
    for (int i = 0; i < n && p != to; i++) begin
      d += seg(p, (p + 1) % n);
      p = (p + 1) % n;
    end
    return d;
  endfunction

  function automatic logic [15:0] clip(longint unsigned v);
    return v > 65535 ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] shaped_speed(beat_t b);
    int n, near, apex, a, c;
    longint unsigned best, d, len, trav, ad, maxd, maxl, curv, es, xs, ta, fa, num, den;
    logic [15:0] dif;
    bit found, alt;
    n = m_count > NWP ? NWP : int'(m_count);
    if (!m_mode[csshp_pkg::MODE_EN] || b.base == 0 || n < 3) return b.base;
    best = '1; near = 0;
    for (int i = 0; i < n; i++) begin
      d = dist2($signed(b.ex), $signed(b.ey), mx[i], my[i]);
      if (d < best) begin
        best = d;
        near = i;
      end
    end
    trav = 0; maxd = 0; maxl = 1; found = 0; apex = 0;
    for (int s = 0; s < n && trav < m_search; s++) begin
      a = (near + s) % n;
      c = (a + 1) % n;
      len = seg(a, c);
      if (len > 0) begin
        dif = myaw[c] - myaw[a];
        ad = dif >= 32768 ? 65536 - dif : dif;
        if (ad * maxl > maxd * len) begin
          maxd = ad; maxl = len; apex = c; found = 1;
        end
      end
      trav += len;
    end
    if (!found) return b.base;
    curv = (maxd * 512 * 64'd1686629713) / (maxl << 29);
    if (curv < m_thr) return b.base;
    alt = b.ovt && m_mode[csshp_pkg::MODE_AGGR];
    es = alt ? m_esc[31:16] : m_esc[15:0];
    xs = alt ? m_xsc[31:16] : m_xsc[15:0];
    ta = walk(n, near, apex);
    if (ta <= m_entry) begin
      if (m_entry == 0) begin
        num = es; den = 1;
      end else begin
        num = es * (m_entry - ta) + 16384 * ta; den = m_entry;
      end
      return clip((longint'(b.base) * num) / (den * 16384));
    end
    fa = walk(n, apex, near);
    if (fa > 0 && fa <= m_exit) begin
      num = 16384 * (m_exit - fa) + xs * fa;
      return clip((longint'(b.base) * num) / (longint'(m_exit) * 16384));
    end
    return b.base;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (took) begin
        void'(pending.pop_front());
        if (burst > 0) burst--;
      end
      if (!in_valid || took) begin
        if (gap > 0) gap--;
        if (burst == 0 && gap == 0) begin
          burst = $urandom_range(1, 8);
          gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 20);
        end
        if (pending.size() > 0 && !hold && gap == 0) begin
          in_valid <= 1;
          in_command <= pending[0].cmd;
          in_point_index <= pending[0].idx;
          in_point_x <= pending[0].px;
          in_point_y <= pending[0].py;
          in_point_yaw <= pending[0].pyaw;
          in_ego_x <= pending[0].ex;
          in_ego_y <= pending[0].ey;
          in_base_speed <= pending[0].base;
          in_overtaking <= pending[0].ovt;
        end else begin
          in_valid <= 0;
        end
      end
      took = 0;
      out_ready <= (cycles % 200 < 100) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // predictor runs on accepted input beats
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_valid && in_ready) begin
      took = 1;
      if (in_command == 0) begin
        mx[in_point_index] = in_point_x;
        my[in_point_index] = in_point_y;
        myaw[in_point_index] = in_point_yaw;
        loads++;
      end else begin
        speed_q.push_back(shaped_speed(pending[0]));
        queries++;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      results++;
      if (speed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: target_speed %0d", out_target_speed);
      end else begin
        logic [15:0] want;
        want = speed_q.pop_front();
        if (want !== out_target_speed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("target_speed mismatch: expected %0d actual %0d", want, out_target_speed);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[corner_speed_shaper_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(csshp_pkg::csshp_reg_t r, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      csshp_pkg::REG_MODE:      m_mode = v[1:0];
      csshp_pkg::REG_COUNT:     m_count = v[10:0];
      csshp_pkg::REG_SEARCH:    m_search = 32'(v[23:0]);
      csshp_pkg::REG_THRESHOLD: m_thr = v;
      csshp_pkg::REG_ENTRY:     m_entry = 32'(v[23:0]);
      csshp_pkg::REG_EXIT:      m_exit = 32'(v[23:0]);
      csshp_pkg::REG_ENTRY_SC:  m_esc = v;
      default:                  m_xsc = v;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || speed_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic beat_t load_beat(int i, int px, int py, int yaw);
    beat_t b;
    b = '{default: '0};
    b.cmd = 0; b.idx = 10'(i); b.px = 24'(px); b.py = 24'(py); b.pyaw = 16'(yaw);
    b.ex = 24'($urandom); b.ey = 24'($urandom); b.base = 16'($urandom);
    b.ovt = 1'($urandom);
    return b;
  endfunction

  function automatic beat_t query_beat(int ex, int ey, int base, bit ovt);
    beat_t b;
    b = '{default: '0};
    b.cmd = 1; b.ex = 24'(ex); b.ey = 24'(ey); b.base = 16'(base); b.ovt = ovt;
    b.idx = 10'($urandom); b.px = 24'($urandom); b.py = 24'($urandom);
    b.pyaw = 16'($urandom);
    return b;
  endfunction

  // ring of n points around a circle-ish polygon, with one sharp corner when sharp is set
  task automatic load_ring(int n, int radius, bit sharp);
    int ang;
    for (int i = 0; i < n; i++) begin
      ang = (i * 65536) / n;
      pending.push_back(load_beat(i,
        (i % 4 < 2 ? radius : -radius) + $urandom_range(0, radius / 4),
        (i % 4 == 1 || i % 4 == 2 ? radius : -radius) + $urandom_range(0, radius / 4),
        sharp && i == n / 2 ? ang + 20000 : ang + $urandom_range(0, 300)));
    end
  endtask

  task automatic set_all(logic [1:0] md, int cnt, logic [31:0] s, logic [31:0] th,
                         logic [31:0] en, logic [31:0] ex, logic [31:0] es,
                         logic [31:0] xs);
    write_reg(csshp_pkg::REG_MODE, 32'(md));
    write_reg(csshp_pkg::REG_COUNT, 32'(cnt));
    write_reg(csshp_pkg::REG_SEARCH, s);
    write_reg(csshp_pkg::REG_THRESHOLD, th);
    write_reg(csshp_pkg::REG_ENTRY, en);
    write_reg(csshp_pkg::REG_EXIT, ex);
    write_reg(csshp_pkg::REG_ENTRY_SC, es);
    write_reg(csshp_pkg::REG_EXIT_SC, xs);
  endtask

  task automatic random_queries(int k, int span);
    int r;
    for (int i = 0; i < k; i++) begin
      r = $urandom_range(0, 9);
      pending.push_back(query_beat($urandom_range(0, 2 * span) - span,
        $urandom_range(0, 2 * span) - span,
        r == 0 ? 0 : (r == 1 ? 65535 : $urandom_range(1, 65535)), 1'($urandom)));
    end
  endtask

  initial begin
    int n;
    m_mode = 0; m_count = 0; m_search = 0; m_thr = 0;
    m_entry = 0; m_exit = 0; m_esc = 0; m_xsc = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extreme coordinates, tiny ring
    pending.push_back(load_beat(0, 24'h7FFFFF, 24'h7FFFFF, 0));
    pending.push_back(load_beat(1, 24'h800000, 24'h800000, 16'hFFFF));
    pending.push_back(load_beat(2, 0, 0, 16'h8000));
    pending.push_back(load_beat(3, 0, 0, 16'h8000));
    pending.push_back(query_beat(0, 0, 1000, 0));
    drain();
    set_all(2'b11, 3, 32'hFFFFFF, 0, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFF_0000, 32'h0000_FFFF);
    pending.push_back(query_beat(24'h7FFFFF, 24'h7FFFFF, 65535, 1));
    pending.push_back(query_beat(24'h800000, 24'h800000, 65535, 0));
    pending.push_back(query_beat(0, 0, 0, 1));
    pending.push_back(query_beat(100, 100, 1, 1));
    drain();
    // zero-length segment ring of four with duplicate point, zero entry distance
    set_all(2'b01, 4, 32'hFFFFFF, 0, 0, 500, 32'h2000_2000, 32'h8000_8000);
    pending.push_back(query_beat(0, 0, 12345, 0));
    pending.push_back(query_beat(-5, 3, 500, 1));
    // planner off, too few points, threshold maximum
    drain();
    write_reg(csshp_pkg::REG_COUNT, 32'd2);
    pending.push_back(query_beat(0, 0, 7, 0));
    drain();
    set_all(2'b10, 1024, 0, 32'hFFFFFFFF, 0, 0, 0, 0);
    pending.push_back(query_beat(0, 0, 7, 0));
    drain();

    // random phases: rings with random content
    for (int ph = 0; ph < 6; ph++) begin
      n = (ph == 5) ? 24 : $urandom_range(3, 12);
      load_ring(n, $urandom_range(200, 60000), 1'($urandom));
      if (ph == 2) pending.push_back(load_beat($urandom_range(n, 1023), 0, 0, 0));
      drain();
      set_all(2'($urandom), ph == 3 ? 2047 & n : n, 32'($urandom_range(0, 2000000)),
              ph == 1 ? 32'hFFFFFFFF : 32'($urandom_range(0, 40000)),
              32'($urandom_range(0, 400000)), 32'($urandom_range(0, 400000)),
              32'($urandom), 32'($urandom));
      write_reg(csshp_pkg::REG_MODE, ph == 0 ? 32'd1 : 32'd3);
      random_queries(ph == 5 ? 4 : 6, 100000);
      if (ph == 3) begin
        while (pending.size() > 3) @(posedge clk);
        hold = 1;
        while (speed_q.size() > 0 || in_valid) @(posedge clk);
        repeat (30) @(posedge clk);
        hold = 0;
      end
      drain();
    end

    drain();
    $display("covered %0d loads and %0d queries, %0d results checked, %0d mismatches",
             loads, queries, results, mismatches);
    if (mismatches == 0 && speed_q.size() == 0)
      $display("[corner_speed_shaper_top] OK");
    else
      $display("[corner_speed_shaper_top] ERROR");
    $finish;
  end
endmodule

// File: filelist.f
design/csshp_pkg.sv
design/csshp_isqrt.sv
design/csshp_div.sv
design/csshp_core.sv
design/corner_speed_shaper_top.sv
dv/corner_speed_shaper_top_test.sv
